// ===== rtl/block_bitmap_fit_allocator_assert.svh =====
// Assertion macros for the bitmap fit allocator.
// Included by the top level; no other dependencies.
`ifndef BLOCK_BITMAP_FIT_ALLOCATOR_ASSERT_SVH
`define BLOCK_BITMAP_FIT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define BBFA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BBFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BBFA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define BBFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/bbfa_pkg.sv =====
// Shared constants, state and command types for the bitmap fit allocator.
// No dependencies.
`timescale 1ns / 1ps
package bbfa_pkg;
  localparam int unsigned NUM_BLOCKS     = 1024;
  localparam int unsigned BITS_PER_BLOCK = 8;
  localparam int unsigned BLOCK_SHIFT    = $clog2(BITS_PER_BLOCK);
  localparam int unsigned SIZE_W         = 14;
  localparam int unsigned START_W        = 10;
  localparam int unsigned END_W          = 11;
  localparam int unsigned COUNT_W        = 11;
  localparam int unsigned LEN_W          = SIZE_W + 1 - BLOCK_SHIFT;
  localparam int unsigned APB_AW         = 3;
  localparam int unsigned APB_DW         = 32;

  localparam logic REQ_RELEASE  = 1'b1;
  localparam logic FIT_NEXT     = 1'b1;
  localparam logic REG_FIT_MODE = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_MARK,
    ST_RELEASE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic clr_step;
    logic scan_step;
    logic mark_step;
    logic rel_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_rel;
    logic len_ok;
    logic rel_empty;
    logic found;
    logic scan_end;
    logic mark_last;
    logic rel_end;
  } stat_t;
endpackage

// ===== rtl/bbfa_req_if.sv =====
// Request channel: valid/ready handshake with the request word.
// Depends on bbfa_pkg for field widths.
`timescale 1ns / 1ps
interface bbfa_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [bbfa_pkg::SIZE_W-1:0]  size_bits;
  logic [bbfa_pkg::START_W-1:0] release_start;
  logic [bbfa_pkg::END_W-1:0]   release_end;

  modport source (output valid, req_type, size_bits, release_start, release_end,
                  input ready);
  modport sink (input valid, req_type, size_bits, release_start, release_end,
                output ready);
endinterface

// ===== rtl/bbfa_res_if.sv =====
// Result channel: valid/ready handshake with the result word.
// Depends on bbfa_pkg for field widths.
`timescale 1ns / 1ps
interface bbfa_res_if;
  logic                         valid;
  logic                         ready;
  logic                         granted;
  logic [bbfa_pkg::START_W-1:0] start_block;
  logic [bbfa_pkg::END_W-1:0]   end_block;
  logic [bbfa_pkg::COUNT_W-1:0] free_count;

  modport source (output valid, granted, start_block, end_block, free_count,
                  input ready);
  modport sink (input valid, granted, start_block, end_block, free_count,
                output ready);
endinterface

// ===== rtl/block_bitmap_fit_allocator.sv =====
// Bitmap block allocator with first-fit and next-fit placement.
// Requests arrive on req_i (allocate a size in bits, or release a block range);
// each request yields one result word on res_o: granted flag, run or range
// bounds and the free block count after the request.
// fit_mode is written over the APB port at byte address 0 (bit 0).
// After reset the bitmap is cleared one block a cycle, with req_i.ready low;
// configuration writes are taken during that pass.
// Steps from accept to result valid, by request kind:
//   allocate refused on size or free count, or empty release: straight to the result;
//   allocate with no fitting run: scan up to the top block;
//   granted allocate: scan until a run fits, the scan reading one
//   bitmap entry a cycle from the single memory read port, then marking one
//   block a cycle on the write port;
//   release: the range is read one block a cycle, each set block cleared.
// One request is in work at a time; the next word is accepted while a result
// still waits in the output register. If the receiver stalls, the finished
// result holds and a second finished request waits until it is taken.
// Depends on bbfa_pkg, bbfa_req_if, bbfa_res_if, bbfa_ctrl and bbfa_dp.
`timescale 1ns / 1ps
`include "block_bitmap_fit_allocator_assert.svh"
module block_bitmap_fit_allocator #(
  parameter int unsigned NUM_BLOCKS = bbfa_pkg::NUM_BLOCKS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bbfa_req_if.sink                      req_i,
  bbfa_res_if.source                    res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bbfa_pkg::APB_AW-1:0]   paddr,
  input  logic [bbfa_pkg::APB_DW-1:0]   pwdata,
  output logic [bbfa_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  logic            fit_mode_q;
  bbfa_pkg::cmd_t  cmd;
  bbfa_pkg::stat_t stat;
  logic            reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = paddr[2] == bbfa_pkg::REG_FIT_MODE;
  assign prdata  = reg_hit ? bbfa_pkg::APB_DW'(fit_mode_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      fit_mode_q <= pwdata[0];
    end
  end

  bbfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .out_ready_i (res_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_ready_o  (req_i.ready),
    .out_valid_o (res_o.valid)
  );

  bbfa_dp #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .fit_mode_i      (fit_mode_q),
    .req_type_i      (req_i.req_type),
    .size_bits_i     (req_i.size_bits),
    .release_start_i (req_i.release_start),
    .release_end_i   (req_i.release_end),
    .stat_o          (stat),
    .granted_o       (res_o.granted),
    .start_block_o   (res_o.start_block),
    .end_block_o     (res_o.end_block),
    .free_count_o    (res_o.free_count)
  );

  `BBFA_ASSERT_IMPL(a_refused_zero, clk_i, rst_ni, res_o.valid && !res_o.granted, (res_o.start_block == '0) && (res_o.end_block == '0))
  `BBFA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, req_i.valid && req_i.ready, !req_i.ready)
  `BBFA_ASSERT_IMPL(a_free_bound, clk_i, rst_ni, res_o.valid, 32'(res_o.free_count) <= 32'(NUM_BLOCKS))
endmodule

// ===== rtl/bbfa_ctrl.sv =====
// Controller state machine: sequences clear, scan, mark and release steps.
// Depends on bbfa_pkg for state, command and status types.
`timescale 1ns / 1ps
module bbfa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_ready_i,
  input  bbfa_pkg::stat_t stat_i,
  output bbfa_pkg::cmd_t  cmd_o,
  output logic            in_ready_o,
  output logic            out_valid_o
);
  bbfa_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bbfa_pkg::ST_CLEAR: begin
        if (stat_i.clr_last) state_d = bbfa_pkg::ST_IDLE;
      end
      bbfa_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = bbfa_pkg::ST_CHECK;
      end
      bbfa_pkg::ST_CHECK: begin
        if (stat_i.is_rel) begin
          state_d = stat_i.rel_empty ? bbfa_pkg::ST_DONE : bbfa_pkg::ST_RELEASE;
        end else begin
          state_d = stat_i.len_ok ? bbfa_pkg::ST_SCAN : bbfa_pkg::ST_DONE;
        end
      end
      bbfa_pkg::ST_SCAN: begin
        if (stat_i.found) state_d = bbfa_pkg::ST_MARK;
        else if (stat_i.scan_end) state_d = bbfa_pkg::ST_DONE;
      end
      bbfa_pkg::ST_MARK: begin
        if (stat_i.mark_last) state_d = bbfa_pkg::ST_DONE;
      end
      bbfa_pkg::ST_RELEASE: begin
        if (stat_i.rel_end) state_d = bbfa_pkg::ST_DONE;
      end
      bbfa_pkg::ST_DONE: begin
        if (out_free) state_d = bbfa_pkg::ST_IDLE;
      end
      default: state_d = bbfa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      bbfa_pkg::ST_CLEAR:   cmd_o.clr_step = 1'b1;
      bbfa_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      bbfa_pkg::ST_CHECK:   cmd_o = '0;
      bbfa_pkg::ST_SCAN:    cmd_o.scan_step = 1'b1;
      bbfa_pkg::ST_MARK:    cmd_o.mark_step = 1'b1;
      bbfa_pkg::ST_RELEASE: cmd_o.rel_step = 1'b1;
      bbfa_pkg::ST_DONE:    cmd_o.load_out = out_free;
      default:              cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bbfa_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
endmodule

// ===== rtl/bbfa_dp.sv =====
// Datapath: occupancy bitmap memory, scan and release counters, free count,
// next-fit pointer and result registers. Depends on bbfa_pkg.
`timescale 1ns / 1ps
module bbfa_dp #(
  parameter int unsigned NUM_BLOCKS = bbfa_pkg::NUM_BLOCKS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bbfa_pkg::cmd_t               cmd_i,
  input  logic                         fit_mode_i,
  input  logic                         req_type_i,
  input  logic [bbfa_pkg::SIZE_W-1:0]  size_bits_i,
  input  logic [bbfa_pkg::START_W-1:0] release_start_i,
  input  logic [bbfa_pkg::END_W-1:0]   release_end_i,
  output bbfa_pkg::stat_t              stat_o,
  output logic                         granted_o,
  output logic [bbfa_pkg::START_W-1:0] start_block_o,
  output logic [bbfa_pkg::END_W-1:0]   end_block_o,
  output logic [bbfa_pkg::COUNT_W-1:0] free_count_o
);
  localparam int unsigned AW = $clog2(NUM_BLOCKS);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned CW = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned LW = bbfa_pkg::LEN_W;
  localparam int unsigned MW = (CW > LW) ? CW : LW;
  localparam int unsigned XW = (PW > bbfa_pkg::END_W) ? PW : bbfa_pkg::END_W;

  logic bitmap_mem [NUM_BLOCKS];
  logic rdata_q;

  logic                         req_rel_q;
  logic [LW-1:0]                len_q;
  logic [bbfa_pkg::START_W-1:0] rs_q;
  logic [PW-1:0]                re_q;
  logic [PW-1:0]                addr_q;
  logic                         pend_q;
  logic [AW-1:0]                tag_q;
  logic [CW-1:0]                run_q;
  logic [AW-1:0]                first_q;
  logic [PW-1:0]                end_q;
  logic [CW-1:0]                free_q;
  logic [AW-1:0]                ptr_q;
  logic                         ok_q;

  logic [bbfa_pkg::SIZE_W:0]    size_rnd;
  logic [LW-1:0]                len_in;
  logic [XW-1:0]                re_x;
  logic [PW-1:0]                re_clamp;
  logic [PW-1:0]                addr_init;
  logic [CW-1:0]                run_inc;
  logic [AW-1:0]                first_new;
  logic                         in_range;
  logic                         mem_re;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic                         mem_wdata;
  logic                         found;
  logic                         mark_last;
  logic                         clr_last;

  assign size_rnd = {1'b0, size_bits_i} +
                    (bbfa_pkg::SIZE_W + 1)'(bbfa_pkg::BITS_PER_BLOCK - 1);
  assign len_in   = size_rnd[bbfa_pkg::SIZE_W:bbfa_pkg::BLOCK_SHIFT];
  assign re_x     = XW'(release_end_i);
  assign re_clamp = (re_x > XW'(NUM_BLOCKS)) ? PW'(NUM_BLOCKS) : PW'(re_x);

  always_comb begin
    if (req_type_i == bbfa_pkg::REQ_RELEASE) addr_init = PW'(release_start_i);
    else if (fit_mode_i == bbfa_pkg::FIT_NEXT) addr_init = {1'b0, ptr_q};
    else addr_init = '0;
  end

  assign run_inc   = run_q + CW'(1);
  assign first_new = (run_q == '0) ? tag_q : first_q;
  assign in_range  = cmd_i.scan_step ? (addr_q < PW'(NUM_BLOCKS)) : (addr_q < re_q);
  assign mem_re    = (cmd_i.scan_step || cmd_i.rel_step) && in_range;
  assign found     = cmd_i.scan_step && pend_q && !rdata_q &&
                     (MW'(run_inc) >= MW'(len_q));
  assign mark_last = (addr_q + PW'(1)) == end_q;
  assign clr_last  = addr_q == PW'(NUM_BLOCKS - 1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q[AW-1:0];
    mem_wdata = 1'b0;
    if (cmd_i.clr_step) begin
      mem_we = 1'b1;
    end else if (cmd_i.mark_step) begin
      mem_we    = 1'b1;
      mem_wdata = 1'b1;
    end else if (cmd_i.rel_step) begin
      mem_we    = pend_q && rdata_q;
      mem_waddr = tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) bitmap_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= bitmap_mem[addr_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      pend_q <= 1'b0;
      free_q <= CW'(NUM_BLOCKS);
      ptr_q  <= '0;
    end else begin
      pend_q <= mem_re;
      if (cmd_i.accept) begin
        addr_q <= addr_init;
      end else if (cmd_i.clr_step) begin
        addr_q <= clr_last ? '0 : addr_q + PW'(1);
      end else if (found) begin
        addr_q <= {1'b0, first_new};
      end else if (mem_re) begin
        addr_q <= addr_q + PW'(1);
      end else if (cmd_i.mark_step) begin
        addr_q <= addr_q + PW'(1);
      end
      if (cmd_i.mark_step && mark_last) begin
        free_q <= free_q - CW'(len_q);
        if (fit_mode_i == bbfa_pkg::FIT_NEXT) ptr_q <= first_q;
      end else if (cmd_i.rel_step && pend_q && rdata_q) begin
        free_q <= free_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_rel_q <= req_type_i == bbfa_pkg::REQ_RELEASE;
      ok_q      <= req_type_i == bbfa_pkg::REQ_RELEASE;
      len_q     <= len_in;
      rs_q      <= release_start_i;
      re_q      <= re_clamp;
      run_q     <= '0;
    end
    if (cmd_i.scan_step && pend_q) begin
      first_q <= first_new;
      run_q   <= rdata_q ? '0 : run_inc;
    end
    if (found) end_q <= PW'(tag_q) + PW'(1);
    if (mem_re) tag_q <= addr_q[AW-1:0];
    if (cmd_i.mark_step && mark_last) ok_q <= 1'b1;
    if (cmd_i.load_out) begin
      granted_o    <= ok_q;
      free_count_o <= bbfa_pkg::COUNT_W'(free_q);
      if (!ok_q) begin
        start_block_o <= '0;
        end_block_o   <= '0;
      end else if (req_rel_q) begin
        start_block_o <= rs_q;
        end_block_o   <= bbfa_pkg::END_W'(re_q);
      end else begin
        start_block_o <= bbfa_pkg::START_W'(first_q);
        end_block_o   <= bbfa_pkg::END_W'(end_q);
      end
    end
  end

  always_comb begin
    stat_o           = '0;
    stat_o.clr_last  = clr_last;
    stat_o.is_rel    = req_rel_q;
    stat_o.len_ok    = (len_q != '0) && (MW'(len_q) <= MW'(free_q));
    stat_o.rel_empty = XW'(rs_q) >= XW'(re_q);
    stat_o.found     = found;
    stat_o.scan_end  = !pend_q && (addr_q == PW'(NUM_BLOCKS));
    stat_o.mark_last = mark_last;
    stat_o.rel_end   = !pend_q && (addr_q >= re_q);
  end
endmodule
